// ===== hdl/posting_list_one_gap_stats_macros.svh =====
// Assertion helpers for the checker file.
`ifndef POSTING_LIST_ONE_GAP_STATS_MACROS_SVH
`define POSTING_LIST_ONE_GAP_STATS_MACROS_SVH

// Check a property on the rising edge, skipped while reset is high.
`define PLOGS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on the rising edge, reset included.
`define PLOGS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/plogs_pkg.sv =====
`timescale 1ns / 1ps

package plogs_pkg;

  localparam int WORD_W  = 32;
  localparam int FIELD_W = 48;

  localparam logic KIND_STREAM = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] word;
  } item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] total_postings;
    logic [FIELD_W-1:0] hit_postings;
    logic [FIELD_W-1:0] list_count;
    logic [FIELD_W-1:0] clean_blocks;
    logic [FIELD_W-1:0] full_block_count;
  } report_t;

  // Increment request for one saturating counter.
  typedef struct packed {
    logic              en;
    logic [WORD_W-1:0] inc;
  } cnt_ctl_t;

  function automatic logic [FIELD_W-1:0] to_field(logic [63:0] v);
    return v[FIELD_W-1:0];
  endfunction

endpackage

// ===== hdl/posting_list_one_gap_stats.sv =====
`timescale 1ns / 1ps

// Statistics over a stream of length-prefixed posting lists.
// Request channel (req_valid / req_ready / req): each transaction carries a
// kind bit and a 32-bit word. Kind stream feeds a list header or a posting;
// kind report asks for the five counters. Report channel (rpt_valid /
// rpt_ready / rpt) returns one transaction per report request, none for
// stream words. cfg_we / cfg_wdata write gap_mode (1 = gap compare against
// the previous posting, 0 = compare against one); write it only while idle.
// A report request is registered in the input stage and then in rpt.
// Throughput: one request per cycle while req_ready is high, set by the
// single register stage that updates the list state and the saturating
// counters each cycle. While a report waits for rpt_ready, stream words keep
// being accepted; a second report holds in the input stage and req_ready
// drops until the first report is taken.
// Reset (rst, synchronous) clears all counters and the list state, sets
// gap_mode to 1 and expects a header as the next stream word.
module posting_list_one_gap_stats #(
  parameter int BLOCK_LEN   = 128,
  parameter int COUNT_WIDTH = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               req_valid,
  output logic               req_ready,
  input  plogs_pkg::item_t   req,
  output logic               rpt_valid,
  input  logic               rpt_ready,
  output plogs_pkg::report_t rpt
);

  localparam int POS_W = $clog2(BLOCK_LEN);
  localparam int W     = plogs_pkg::WORD_W;

  logic             gap_mode;
  logic             s1_valid;
  plogs_pkg::item_t s1_item;
  logic             s1_advance;
  logic             s1_stream;
  logic             s1_report;

  logic             expect_header;
  logic [W-1:0]     postings_left;
  logic [POS_W-1:0] block_position;
  logic             block_all_ones;
  logic [W-1:0]     previous_posting;

  logic             expect_header_next;
  logic [W-1:0]     postings_left_next;
  logic [POS_W-1:0] block_position_next;
  logic             block_all_ones_next;
  logic [W-1:0]     previous_posting_next;

  logic             in_full;
  logic             hit;
  logic             block_last;

  plogs_pkg::cnt_ctl_t total_ctl, ones_ctl, lists_ctl, one_blocks_ctl, blocks_ctl;
  logic [COUNT_WIDTH-1:0] total_cnt, ones_cnt, lists_cnt, one_blocks_cnt, blocks_cnt;

  assign s1_stream  = s1_valid && (s1_item.kind == plogs_pkg::KIND_STREAM);
  assign s1_report  = s1_valid && (s1_item.kind == plogs_pkg::KIND_REPORT);
  assign s1_advance = s1_stream || (s1_report && (!rpt_valid || rpt_ready));
  assign req_ready  = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_mode <= 1'b1;
    end else if (cfg_we) begin
      gap_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      s1_item <= req;
    end
  end

  // A nonzero position means we are inside a full block; at a block start the
  // block is full when enough postings remain to fill it.
  assign in_full    = (block_position != '0) || (postings_left >= W'(BLOCK_LEN));
  assign block_last = (block_position == POS_W'(BLOCK_LEN - 1));

  always_comb begin
    if (gap_mode) begin
      hit = (previous_posting != '1) && (s1_item.word == previous_posting + W'(1));
    end else begin
      hit = (s1_item.word == W'(1));
    end
  end

  always_comb begin
    expect_header_next    = expect_header;
    postings_left_next    = postings_left;
    block_position_next   = block_position;
    block_all_ones_next   = block_all_ones;
    previous_posting_next = previous_posting;
    total_ctl             = '{en: 1'b0, inc: s1_item.word};
    lists_ctl             = '{en: 1'b0, inc: W'(1)};
    ones_ctl              = '{en: 1'b0, inc: W'(1)};
    one_blocks_ctl        = '{en: 1'b0, inc: W'(1)};
    blocks_ctl            = '{en: 1'b0, inc: W'(1)};

    if (s1_stream) begin
      if (expect_header) begin
        lists_ctl.en          = 1'b1;
        total_ctl.en          = 1'b1;
        postings_left_next    = s1_item.word;
        block_position_next   = '0;
        block_all_ones_next   = 1'b1;
        previous_posting_next = '0;
        expect_header_next    = (s1_item.word == '0);
      end else begin
        if (in_full) begin
          ones_ctl.en = hit;
          if (gap_mode) begin
            previous_posting_next = s1_item.word;
          end
          if (block_last) begin
            blocks_ctl.en       = 1'b1;
            one_blocks_ctl.en   = block_all_ones && hit;
            block_position_next = '0;
            block_all_ones_next = 1'b1;
          end else begin
            block_position_next = block_position + POS_W'(1);
            block_all_ones_next = block_all_ones && hit;
          end
        end
        if (postings_left != '0) begin
          postings_left_next = postings_left - W'(1);
        end
        if (postings_left_next == '0) begin
          expect_header_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header    <= 1'b1;
      postings_left    <= '0;
      block_position   <= '0;
      block_all_ones   <= 1'b1;
      previous_posting <= '0;
    end else begin
      expect_header    <= expect_header_next;
      postings_left    <= postings_left_next;
      block_position   <= block_position_next;
      block_all_ones   <= block_all_ones_next;
      previous_posting <= previous_posting_next;
    end
  end

  plogs_sat_ctr #(.WIDTH(COUNT_WIDTH)) u_total (
    .clk(clk), .rst(rst), .ctl(total_ctl), .count(total_cnt)
  );
  plogs_sat_ctr #(.WIDTH(COUNT_WIDTH)) u_ones (
    .clk(clk), .rst(rst), .ctl(ones_ctl), .count(ones_cnt)
  );
  plogs_sat_ctr #(.WIDTH(COUNT_WIDTH)) u_lists (
    .clk(clk), .rst(rst), .ctl(lists_ctl), .count(lists_cnt)
  );
  plogs_sat_ctr #(.WIDTH(COUNT_WIDTH)) u_one_blocks (
    .clk(clk), .rst(rst), .ctl(one_blocks_ctl), .count(one_blocks_cnt)
  );
  plogs_sat_ctr #(.WIDTH(COUNT_WIDTH)) u_blocks (
    .clk(clk), .rst(rst), .ctl(blocks_ctl), .count(blocks_cnt)
  );

  // Hold the report until taken; load a new one as the old one leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
    end else if (s1_report && s1_advance) begin
      rpt_valid <= 1'b1;
    end else if (rpt_ready) begin
      rpt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_report && s1_advance) begin
      rpt.total_postings   <= plogs_pkg::to_field(64'(total_cnt));
      rpt.hit_postings     <= plogs_pkg::to_field(64'(ones_cnt));
      rpt.list_count       <= plogs_pkg::to_field(64'(lists_cnt));
      rpt.clean_blocks     <= plogs_pkg::to_field(64'(one_blocks_cnt));
      rpt.full_block_count <= plogs_pkg::to_field(64'(blocks_cnt));
    end
  end

endmodule

// ===== hdl/plogs_sat_ctr.sv =====
`timescale 1ns / 1ps

module plogs_sat_ctr #(
  parameter int WIDTH = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  plogs_pkg::cnt_ctl_t  ctl,
  output logic [WIDTH-1:0]     count
);

  logic [WIDTH:0] sum;

  assign sum = {1'b0, count} + (WIDTH+1)'(ctl.inc);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.en) begin
      // carry out means the add passed the top: stick at all ones
      count <= sum[WIDTH] ? '1 : sum[WIDTH-1:0];
    end
  end

endmodule

// ===== hdl/plogs_checker.sv =====
`timescale 1ns / 1ps
`include "posting_list_one_gap_stats_macros.svh"

module plogs_checker #(
  parameter int COUNT_WIDTH = 48
) (
  input logic               clk,
  input logic               rst,
  input logic               rpt_valid,
  input logic               rpt_ready,
  input plogs_pkg::report_t rpt
);

  localparam logic NO_WRAP = (COUNT_WIDTH <= plogs_pkg::FIELD_W);

  `PLOGS_ASSERT_ALWAYS(a_rst_clears_rpt, clk, rst |=> !rpt_valid, "report valid after reset")
  `PLOGS_ASSERT(a_rpt_hold, clk, rst, rpt_valid && !rpt_ready |=> rpt_valid && $stable(rpt), "stalled report changed")
  `PLOGS_ASSERT(a_blocks_order, clk, rst, NO_WRAP && rpt_valid |-> rpt.clean_blocks <= rpt.full_block_count, "more all-ones blocks than full blocks")
  `PLOGS_ASSERT(a_lists_grow, clk, rst, NO_WRAP && rpt_valid && rpt_ready ##1 rpt_valid |-> rpt.list_count >= $past(rpt.list_count), "list count went down")

endmodule

bind posting_list_one_gap_stats plogs_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_checker (.*);

// ===== bench/tb_posting_list_one_gap_stats.sv =====
`timescale 1ns / 1ps

module tb_posting_list_one_gap_stats;

  localparam int BLOCK = 128;
  localparam int COUNT_W = 48;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_W) - 64'd1;
  localparam int CYCLE_LIMIT = 200000;
  // leave margin after the last report before a mode write
  localparam int SETTLE = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic req_valid = 1'b0;
  logic req_ready;
  plogs_pkg::item_t req = '0;
  logic rpt_valid;
  logic rpt_ready = 1'b0;
  plogs_pkg::report_t rpt;

  posting_list_one_gap_stats #(
    .BLOCK_LEN(BLOCK),
    .COUNT_WIDTH(COUNT_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rpt_valid(rpt_valid),
    .rpt_ready(rpt_ready),
    .rpt(rpt)
  );

  // predictor state
  bit mode_gap = 1'b1;
  bit hdr_due = 1'b1;
  logic [31:0] left_cnt = '0;
  logic [31:0] region_left = '0;
  logic [31:0] last_post = '0;
  int blk_pos = 0;
  bit blk_clean = 1'b1;
  longint unsigned cnt_total = 0;
  longint unsigned cnt_ones = 0;
  longint unsigned cnt_lists = 0;
  longint unsigned cnt_clean_blocks = 0;
  longint unsigned cnt_blocks = 0;

  plogs_pkg::report_t pending_reports[$];

  int mismatches = 0;
  int reports_seen = 0;
  int items_sent = 0;
  int stream_words = 0;
  int mode_writes = 0;
  int cycles = 0;
  int rdy_hold = 0;
  bit idle_on = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned sat_inc(longint unsigned acc, longint unsigned inc);
    if (acc >= COUNT_MAX || inc > COUNT_MAX - acc) return COUNT_MAX;
    return acc + inc;
  endfunction

  function automatic plogs_pkg::item_t mk_item(logic kind, logic [31:0] word);
    plogs_pkg::item_t it;
    it.kind = kind;
    it.word = word;
    return it;
  endfunction

  // Advance the list statistics by one accepted transaction.
  function automatic void track_item(plogs_pkg::item_t it);
    plogs_pkg::report_t r;
    logic hit;
    if (it.kind == plogs_pkg::KIND_REPORT) begin
      r.total_postings = cnt_total[COUNT_W-1:0];
      r.hit_postings = cnt_ones[COUNT_W-1:0];
      r.list_count = cnt_lists[COUNT_W-1:0];
      r.clean_blocks = cnt_clean_blocks[COUNT_W-1:0];
      r.full_block_count = cnt_blocks[COUNT_W-1:0];
      pending_reports.push_back(r);
      return;
    end
    stream_words++;
    if (hdr_due) begin
      cnt_lists = sat_inc(cnt_lists, 1);
      cnt_total = sat_inc(cnt_total, longint'(it.word));
      left_cnt = it.word;
      region_left = (it.word / 32'(BLOCK)) * 32'(BLOCK);
      blk_pos = 0;
      blk_clean = 1'b1;
      last_post = '0;
      hdr_due = (it.word == 32'd0);
      return;
    end
    if (region_left != 32'd0) begin
      if (mode_gap)
        hit = (last_post != 32'hFFFF_FFFF) && (it.word == last_post + 32'd1);
      else
        hit = (it.word == 32'd1);
      if (hit)
        cnt_ones = sat_inc(cnt_ones, 1);
      else
        blk_clean = 1'b0;
      if (mode_gap)
        last_post = it.word;
      region_left--;
      blk_pos++;
      if (blk_pos >= BLOCK) begin
        cnt_blocks = sat_inc(cnt_blocks, 1);
        if (blk_clean) cnt_clean_blocks = sat_inc(cnt_clean_blocks, 1);
        blk_pos = 0;
        blk_clean = 1'b1;
      end
    end
    if (left_cnt != 32'd0) left_cnt--;
    if (left_cnt == 32'd0) hdr_due = 1'b1;
  endfunction

  task automatic check_field(string name, logic [plogs_pkg::FIELD_W-1:0] exp_v,
                             logic [plogs_pkg::FIELD_W-1:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0h, got %0h", name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin : report_checker
    plogs_pkg::report_t exp_r;
    if (!rst && rpt_valid && rpt_ready) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("report with none pending: got %0h", rpt);
      end else begin
        exp_r = pending_reports.pop_front();
        check_field("total_postings", exp_r.total_postings, rpt.total_postings);
        check_field("hit_postings", exp_r.hit_postings, rpt.hit_postings);
        check_field("list_count", exp_r.list_count, rpt.list_count);
        check_field("clean_blocks", exp_r.clean_blocks, rpt.clean_blocks);
        check_field("full_block_count", exp_r.full_block_count, rpt.full_block_count);
      end
    end
  end

  // Back-pressure on the report side in short random bursts.
  always @(posedge clk) begin
    if (rdy_hold > 0) begin
      rpt_ready <= 1'b0;
      rdy_hold <= rdy_hold - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rpt_ready <= 1'b0;
      rdy_hold <= $urandom_range(0, 3);
    end else begin
      rpt_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("cycle limit of %0d reached, %0d reports still pending",
               CYCLE_LIMIT, pending_reports.size());
      $display("posting_list_one_gap_stats test failed");
      $finish;
    end
  end

  // Hold valid until the transaction is taken, then update the predictor.
  task automatic send_item(plogs_pkg::item_t it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= it;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    items_sent++;
    track_item(it);
  endtask

  task automatic send_word(logic [31:0] w);
    send_item(mk_item(plogs_pkg::KIND_STREAM, w));
  endtask

  task automatic send_report();
    send_item(mk_item(plogs_pkg::KIND_REPORT, $urandom()));
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_gap = m;
    mode_writes++;
  endtask

  // quality 0: every posting counts, 1: rare misses, 2: arbitrary values
  function automatic logic [31:0] pick_posting(int quality);
    if (quality == 2 || (quality == 1 && $urandom_range(0, 19) == 0)) begin
      case ($urandom_range(0, 5))
        0: return 32'd0;
        1: return 32'hFFFF_FFFF;
        2: return last_post;
        3: return 32'd1;
        default: return $urandom();
      endcase
    end
    return mode_gap ? last_post + 32'd1 : 32'd1;
  endfunction

  task automatic send_list(int len, int quality);
    send_word(32'(len));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 29) == 0) send_report();
      if ($urandom_range(0, 299) == 0) write_mode(!mode_gap);
      send_word(pick_posting(quality));
    end
  endtask

  task automatic test_directed();
    write_mode(1'b1);
    send_report();
    // empty lists
    send_word(32'd0);
    send_word(32'd0);
    send_report();
    // short list, tail block only, report mid-list
    send_word(32'd3);
    send_word(32'hFFFF_FFFF);
    send_report();
    send_word(32'd0);
    send_word(32'd1);
    write_mode(1'b0);
    send_word(32'd2);
    send_word(32'd1);
    send_word(32'hFFFF_FFFF);
    send_report();
    write_mode(1'b1);
    send_word(32'd1);
    send_word(32'h8000_0000);
    send_word(32'd2);
    send_item(mk_item(plogs_pkg::KIND_REPORT, 32'hFFFF_FFFF));
    send_word(32'h5555_5555);
    send_word(32'hAAAA_AAAA);
    send_report();
  endtask

  task automatic test_random_lists(int n_items);
    int stop_at;
    int len;
    int quality;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 5) == 0) write_mode(1'($urandom_range(0, 1)));
      case ($urandom_range(0, 9))
        0, 1, 2: len = $urandom_range(0, 5);
        3: len = $urandom_range(127, 129);
        4: len = $urandom_range(255, 257);
        default: len = $urandom_range(128, 200);
      endcase
      case ($urandom_range(0, 4))
        0, 1: quality = 0;
        2, 3: quality = 1;
        default: quality = 2;
      endcase
      send_list(len, quality);
      if ($urandom_range(0, 1) == 1) send_report();
    end
  endtask

  // One list with the largest header: every posting falls in a full block.
  task automatic test_long_list();
    idle_on = 1'b0;
    write_mode(1'b1);
    send_word(32'hFFFF_FFFF);
    repeat (130) send_word(pick_posting(0));
    send_report();
    // no wrap-around past the top of the range
    send_word(32'hFFFF_FFFE);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    send_report();
    repeat (130) begin
      if ($urandom_range(0, 19) == 0) send_report();
      send_word(pick_posting(1));
    end
    write_mode(1'b0);
    repeat (130) begin
      if ($urandom_range(0, 19) == 0) send_report();
      send_word(pick_posting(1));
    end
    send_report();
    // previous posting was frozen in frequency mode; resume from it
    write_mode(1'b1);
    repeat (140) send_word(pick_posting(0));
    send_report();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_lists(1300);
    test_long_list();
    wait_idle();
    repeat (8) @(posedge clk);
    $display("sent %0d transactions: %0d stream words, %0d reports checked, %0d mode writes",
             items_sent, stream_words, reports_seen, mode_writes);
    $display("stream held %0d lists, %0d full blocks, %0d of them all ones",
             cnt_lists, cnt_blocks, cnt_clean_blocks);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("posting_list_one_gap_stats test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("posting_list_one_gap_stats test failed");
    end
    $finish;
  end

endmodule
